[rtl/ilir_pkg.sv]
// Shared types and constants for the indexed list insert/remove block.
// Used by ilir_front, ilir_queue, ilir_back and indexed_list_insert_remove.
// No dependencies.
package ilir_pkg;

    localparam int DEPTH_DEF   = 16;
    localparam int DATA_W_DEF  = 32;
    localparam int QUEUE_DEPTH = 2;

    localparam int CMD_W  = 2;
    localparam int IDX_W  = 5;
    localparam int ITEM_W = 32;
    localparam int STAT_W = 2;
    localparam int LEN_W  = 5;

    typedef enum logic [CMD_W-1:0] {
        CMD_GET = 2'd0,
        CMD_POP = 2'd1,
        CMD_INS = 2'd2
    } cmd_t;

    typedef enum logic [STAT_W-1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        OP_NONE,
        OP_GET,
        OP_POP,
        OP_INS
    } op_kind_t;

    typedef struct packed {
        op_kind_t kind;
        status_t  status;
    } op_ctrl_t;

    typedef enum logic [2:0] {
        B_IDLE,
        B_POP_FIRST,
        B_POP_MOVE,
        B_INS_MOVE,
        B_INS_PUT,
        B_RESULT
    } back_state_t;

endpackage

[rtl/indexed_list_insert_remove.sv]
// Top level of the positional list: front end, command queue and back end.
// Depends on ilir_pkg, ilir_front, ilir_queue and ilir_back.
//
//   Channel   Handshake             Payload
//   -------   -------------------   -------------------------------
//   in        in_valid / in_stall   cmd[1:0] index[4:0] item[31:0]
//   out       out_valid / out_stall data[31:0] status[1:0] length[4:0]
//
// Get, every rejected command and insert at the length go from idle straight
// to the result state; pop at position p shifts each later entry down one
// place and insert at p below the length shifts entries from p on up one
// place, one entry per cycle through one read and one write port of the entry
// memory. Reset clears the length and the control state; entries need no
// clearing. in_stall rises only while the two-entry command queue is full; a
// finished result stalled at the output holds up the next command.
module indexed_list_insert_remove import ilir_pkg::*; #(
    parameter int DEPTH  = DEPTH_DEF,
    parameter int DATA_W = DATA_W_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [CMD_W-1:0]  cmd,
    input  logic [IDX_W-1:0]  index,
    input  logic [ITEM_W-1:0] item,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [ITEM_W-1:0] data,
    output logic [STAT_W-1:0] status,
    output logic [LEN_W-1:0]  length
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int QW = $bits(op_ctrl_t) + AW + CW + DATA_W;

    logic              q_full;
    logic              q_push;
    op_ctrl_t          f_ctrl;
    logic [AW-1:0]     f_pos;
    logic [CW-1:0]     f_cnt;
    logic [DATA_W-1:0] f_item;
    logic              q_valid;
    logic              q_pop;
    logic [QW-1:0]     q_head;
    op_ctrl_t          b_ctrl;
    logic [AW-1:0]     b_pos;
    logic [CW-1:0]     b_cnt;
    logic [DATA_W-1:0] b_item;

    ilir_front #(
        .DEPTH  (DEPTH),
        .DATA_W (DATA_W)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .cmd      (cmd),
        .index    (index),
        .item     (item),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_ctrl   (f_ctrl),
        .q_pos    (f_pos),
        .q_cnt    (f_cnt),
        .q_item   (f_item)
    );

    ilir_queue #(
        .W  (QW),
        .QD (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .wr_data   ({f_ctrl, f_pos, f_cnt, f_item}),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_valid),
        .rd_data   (q_head)
    );

    assign {b_ctrl, b_pos, b_cnt, b_item} = q_head;

    ilir_back #(
        .DEPTH  (DEPTH),
        .DATA_W (DATA_W)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_pop     (q_pop),
        .q_ctrl    (b_ctrl),
        .q_pos     (b_pos),
        .q_cnt     (b_cnt),
        .q_item    (b_item),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .data      (data),
        .status    (status),
        .length    (length)
    );

endmodule

[rtl/ilir_front.sv]
// Front end: accepts commands, checks them against the running length and
// hands decoded operations to the queue. Depends on ilir_pkg.
module ilir_front import ilir_pkg::*; #(
    parameter int DEPTH  = DEPTH_DEF,
    parameter int DATA_W = DATA_W_DEF,
    localparam int AW = $clog2(DEPTH),
    localparam int CW = $clog2(DEPTH + 1)
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [CMD_W-1:0]  cmd,
    input  logic [IDX_W-1:0]  index,
    input  logic [ITEM_W-1:0] item,
    input  logic              q_full,
    output logic              q_push,
    output op_ctrl_t          q_ctrl,
    output logic [AW-1:0]     q_pos,
    output logic [CW-1:0]     q_cnt,
    output logic [DATA_W-1:0] q_item
);

    localparam int CMP_W = (CW > IDX_W) ? CW : IDX_W;
    localparam int IEW   = (DATA_W > ITEM_W) ? DATA_W : ITEM_W;

    logic [CW-1:0]    count_reg;
    logic [CW-1:0]    count_next;
    logic [CMP_W-1:0] idx_ext;
    logic [CMP_W-1:0] cnt_ext;
    logic [IEW-1:0]   item_ext;
    logic             accept;

    assign idx_ext  = CMP_W'(index);
    assign cnt_ext  = CMP_W'(count_reg);
    assign item_ext = IEW'(item);

    assign in_stall = q_full;
    assign accept   = in_valid && !q_full;
    assign q_push   = accept;
    assign q_pos    = idx_ext[AW-1:0];
    assign q_cnt    = count_reg;
    assign q_item   = item_ext[DATA_W-1:0];

    // The length is tracked here at classification time, so later commands
    // can be checked before the back end has finished moving entries.
    always_comb
    begin
        q_ctrl.kind   = OP_NONE;
        q_ctrl.status = ST_RANGE;
        count_next    = count_reg;
        case (cmd)
            CMD_GET:
            begin
                if (idx_ext < cnt_ext)
                begin
                    q_ctrl.kind   = OP_GET;
                    q_ctrl.status = ST_OK;
                end
            end
            CMD_POP:
            begin
                if (idx_ext < cnt_ext)
                begin
                    q_ctrl.kind   = OP_POP;
                    q_ctrl.status = ST_OK;
                    count_next    = count_reg - CW'(1);
                end
            end
            CMD_INS:
            begin
                if (idx_ext > cnt_ext)
                begin
                    q_ctrl.status = ST_RANGE;
                end
                else if (cnt_ext == CMP_W'(DEPTH))
                begin
                    q_ctrl.status = ST_FULL;
                end
                else
                begin
                    q_ctrl.kind   = OP_INS;
                    q_ctrl.status = ST_OK;
                    count_next    = count_reg + CW'(1);
                end
            end
            default:
            begin
                q_ctrl.kind   = OP_NONE;
                q_ctrl.status = ST_RANGE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else if (accept)
        begin
            count_reg <= count_next;
        end
    end

endmodule

[rtl/ilir_queue.sv]
// Short register FIFO that decouples the front end from the back end.
// Depends on ilir_pkg for the default depth.
module ilir_queue import ilir_pkg::*; #(
    parameter int W  = 8,
    parameter int QD = QUEUE_DEPTH
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push,
    input  logic [W-1:0] wr_data,
    output logic         full,
    input  logic         pop,
    output logic         not_empty,
    output logic [W-1:0] rd_data
);

    localparam int QA  = (QD > 1) ? $clog2(QD) : 1;
    localparam int QCW = $clog2(QD + 1);

    logic [W-1:0]   slots_reg [QD];
    logic [QA-1:0]  wr_ptr_reg;
    logic [QA-1:0]  rd_ptr_reg;
    logic [QCW-1:0] fill_reg;
    logic           do_push;
    logic           do_pop;

    assign full      = (fill_reg == QCW'(QD));
    assign not_empty = (fill_reg != '0);
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;
    assign rd_data   = slots_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slots_reg[wr_ptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == QA'(QD - 1)) ? '0 : wr_ptr_reg + QA'(1);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == QA'(QD - 1)) ? '0 : rd_ptr_reg + QA'(1);
            end
            if (do_push && !do_pop)
            begin
                fill_reg <= fill_reg + QCW'(1);
            end
            else if (do_pop && !do_push)
            begin
                fill_reg <= fill_reg - QCW'(1);
            end
        end
    end

endmodule

[rtl/ilir_back.sv]
// Back end: owns the entry memory, carries out reads and the one-entry-per-
// cycle shifts of pop and insert, and holds the result register.
// Depends on ilir_pkg.
module ilir_back import ilir_pkg::*; #(
    parameter int DEPTH  = DEPTH_DEF,
    parameter int DATA_W = DATA_W_DEF,
    localparam int AW = $clog2(DEPTH),
    localparam int CW = $clog2(DEPTH + 1)
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              q_valid,
    output logic              q_pop,
    input  op_ctrl_t          q_ctrl,
    input  logic [AW-1:0]     q_pos,
    input  logic [CW-1:0]     q_cnt,
    input  logic [DATA_W-1:0] q_item,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [ITEM_W-1:0] data,
    output logic [STAT_W-1:0] status,
    output logic [LEN_W-1:0]  length
);

    localparam int SW  = CW + 1;
    localparam int OEW = (DATA_W > ITEM_W) ? DATA_W : ITEM_W;
    localparam int LEW = (CW > LEN_W) ? CW : LEN_W;

    back_state_t state_reg, state_next;
    op_kind_t    kind_reg, kind_next;
    status_t     stat_reg, stat_next;
    logic [AW-1:0]     pos_reg, pos_next;
    logic [CW-1:0]     cnt_reg, cnt_next;
    logic [DATA_W-1:0] item_reg, item_next;
    logic [AW-1:0]     ptr_reg, ptr_next;
    logic [DATA_W-1:0] hold_reg, hold_next;

    logic              out_valid_reg;
    logic [ITEM_W-1:0] out_data_reg;
    status_t           out_stat_reg;
    logic [LEN_W-1:0]  out_len_reg;
    logic              out_load;

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rd_data_reg;
    logic              rd_en;
    logic [AW-1:0]     rd_addr;
    logic              wr_en;
    logic [AW-1:0]     wr_addr;
    logic [DATA_W-1:0] wr_data;

    logic [SW-1:0]     ptr_ext;
    logic [SW-1:0]     pos_ext;
    logic [SW-1:0]     cnt_ext;
    logic [SW-1:0]     q_pos_ext;
    logic [SW-1:0]     q_last;
    logic [CW-1:0]     len_after;
    logic [DATA_W-1:0] res_data;
    logic [OEW-1:0]    res_data_ext;
    logic [LEW-1:0]    len_ext;

    assign ptr_ext   = SW'(ptr_reg);
    assign pos_ext   = SW'(pos_reg);
    assign cnt_ext   = SW'(cnt_reg);
    assign q_pos_ext = SW'(q_pos);
    assign q_last    = SW'(q_cnt) - SW'(1);

    always_comb
    begin
        case (kind_reg)
            OP_POP:  len_after = cnt_reg - CW'(1);
            OP_INS:  len_after = cnt_reg + CW'(1);
            default: len_after = cnt_reg;
        endcase
        case (kind_reg)
            OP_GET:  res_data = rd_data_reg;
            OP_POP:  res_data = hold_reg;
            default: res_data = '0;
        endcase
    end

    assign res_data_ext = OEW'(res_data);
    assign len_ext      = LEW'(len_after);

    // Reads are registered, so each move reads its source in the cycle before
    // the write to its destination; the read of the next source overlaps.
    always_comb
    begin
        state_next = state_reg;
        kind_next  = kind_reg;
        stat_next  = stat_reg;
        pos_next   = pos_reg;
        cnt_next   = cnt_reg;
        item_next  = item_reg;
        ptr_next   = ptr_reg;
        hold_next  = hold_reg;
        q_pop      = 1'b0;
        rd_en      = 1'b0;
        rd_addr    = ptr_reg;
        wr_en      = 1'b0;
        wr_addr    = ptr_reg;
        wr_data    = rd_data_reg;
        out_load   = 1'b0;
        case (state_reg)
            B_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop      = 1'b1;
                    kind_next  = q_ctrl.kind;
                    stat_next  = q_ctrl.status;
                    pos_next   = q_pos;
                    cnt_next   = q_cnt;
                    item_next  = q_item;
                    ptr_next   = q_pos;
                    state_next = B_RESULT;
                    case (q_ctrl.kind)
                        OP_GET:
                        begin
                            rd_en   = 1'b1;
                            rd_addr = q_pos;
                        end
                        OP_POP:
                        begin
                            rd_en      = 1'b1;
                            rd_addr    = q_pos;
                            state_next = B_POP_FIRST;
                        end
                        OP_INS:
                        begin
                            if (SW'(q_cnt) > q_pos_ext)
                            begin
                                rd_en      = 1'b1;
                                rd_addr    = q_last[AW-1:0];
                                ptr_next   = q_last[AW-1:0];
                                state_next = B_INS_MOVE;
                            end
                            else
                            begin
                                wr_en   = 1'b1;
                                wr_addr = q_pos;
                                wr_data = q_item;
                            end
                        end
                        default:
                        begin
                            state_next = B_RESULT;
                        end
                    endcase
                end
            end
            B_POP_FIRST:
            begin
                hold_next = rd_data_reg;
                if (ptr_ext + SW'(1) < cnt_ext)
                begin
                    rd_en      = 1'b1;
                    rd_addr    = ptr_reg + AW'(1);
                    state_next = B_POP_MOVE;
                end
                else
                begin
                    state_next = B_RESULT;
                end
            end
            B_POP_MOVE:
            begin
                wr_en    = 1'b1;
                wr_addr  = ptr_reg;
                ptr_next = ptr_reg + AW'(1);
                if (ptr_ext + SW'(2) < cnt_ext)
                begin
                    rd_en   = 1'b1;
                    rd_addr = ptr_reg + AW'(2);
                end
                else
                begin
                    state_next = B_RESULT;
                end
            end
            B_INS_MOVE:
            begin
                wr_en   = 1'b1;
                wr_addr = ptr_reg + AW'(1);
                if (ptr_ext > pos_ext)
                begin
                    rd_en    = 1'b1;
                    rd_addr  = ptr_reg - AW'(1);
                    ptr_next = ptr_reg - AW'(1);
                end
                else
                begin
                    state_next = B_INS_PUT;
                end
            end
            B_INS_PUT:
            begin
                wr_en      = 1'b1;
                wr_addr    = pos_reg;
                wr_data    = item_reg;
                state_next = B_RESULT;
            end
            B_RESULT:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_load   = 1'b1;
                    state_next = B_IDLE;
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg <= kind_next;
        stat_reg <= stat_next;
        pos_reg  <= pos_next;
        cnt_reg  <= cnt_next;
        item_reg <= item_next;
        ptr_reg  <= ptr_next;
        hold_reg <= hold_next;
        if (out_load)
        begin
            out_data_reg <= res_data_ext[ITEM_W-1:0];
            out_stat_reg <= stat_reg;
            out_len_reg  <= len_ext[LEN_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign data      = out_data_reg;
    assign status    = out_stat_reg;
    assign length    = out_len_reg;

    a_read_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == B_IDLE && q_valid && (q_ctrl.kind == OP_GET || q_ctrl.kind == OP_POP))
        |-> (q_pos_ext < SW'(q_cnt)))
        else $error("get or pop issued at a position beyond the length");

    a_insert_room: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == B_IDLE && q_valid && q_ctrl.kind == OP_INS)
        |-> (SW'(q_cnt) < SW'(DEPTH) && q_pos_ext <= SW'(q_cnt)))
        else $error("insert issued into a full list or past its end");

    a_pop_move_bounds: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == B_POP_MOVE) |-> (ptr_ext + SW'(1) < cnt_ext))
        else $error("pop shift moved past the last entry");

    a_ins_move_bounds: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == B_INS_MOVE) |-> (ptr_ext >= pos_ext && ptr_ext < cnt_ext))
        else $error("insert shift left the range between position and length");

endmodule
